[hdl/cse_pkg.sv]
package cse_pkg;

  localparam int MAX_KNOTS  = 64;
  localparam int FRAC_BITS  = 16;
  localparam int IDX_W      = $clog2(MAX_KNOTS);
  localparam int CNT_W      = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam int MAC_W      = 98;
  localparam int ACC_W      = 84;

  localparam logic [CFG_IDX_W-1:0] CFG_KNOT_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_EQUIDISTANT = 1'b1;
  localparam logic [CNT_W-1:0]     RST_KNOT_COUNT  = 7'd2;

  typedef struct packed {
    logic              kind;
    logic [5:0]        entry_index;
    logic signed [31:0] knot_position;
    logic signed [31:0] coef_const;
    logic signed [31:0] coef_linear;
    logic signed [31:0] coef_quadratic;
    logic signed [31:0] coef_cubic;
    logic signed [31:0] query_position;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] interp_value;
    logic               in_range;
  } out_item_t;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_WRITE,
    CMD_START,
    CMD_RD_LAST,
    CMD_CHECK,
    CMD_EQ_INIT,
    CMD_DIV,
    CMD_SR_PROBE,
    CMD_SR_CMP,
    CMD_SR_END,
    CMD_LOAD,
    CMD_CAPT,
    CMD_MUL_LO,
    CMD_MUL_HI,
    CMD_MUL_WB,
    CMD_OUT
  } cmd_e;

  typedef enum logic [2:0] {
    OP_SQ,
    OP_CUBE,
    OP_LIN,
    OP_QUAD,
    OP_CUBIC
  } mul_op_e;

  typedef struct packed {
    cmd_e    cmd;
    mul_op_e op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic ok_now;
    logic eq_mode;
    logic step_pos;
    logic sr_more;
    logic div_last;
    logic out_free;
  } dp_status_t;

endpackage

[hdl/cubic_spline_segment_evaluator.sv]
// A write request is stored from the idle state. A query reads the last knot and checks range;
// in range it runs a serial binary search of up to six probes, or the divider in equidistant mode,
// and every query ends with five two-half passes through the shared multiplier.
// One request is in work at a time; the next is taken once the result is in the output register.
// Reset is asynchronous and active low; it clears control and configuration, not the tables.
module cubic_spline_segment_evaluator import cse_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  cse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (in_data_i.kind),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cse_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[hdl/cse_ctrl.sv]
module cse_ctrl import cse_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_kind_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_RDLAST = 12'b000000000010,
    S_CHECK  = 12'b000000000100,
    S_EQ     = 12'b000000001000,
    S_DIV    = 12'b000000010000,
    S_SRCH   = 12'b000000100000,
    S_SCMP   = 12'b000001000000,
    S_LOAD   = 12'b000010000000,
    S_CAPT   = 12'b000100000000,
    S_MLO    = 12'b001000000000,
    S_MHI    = 12'b010000000000,
    S_MWB    = 12'b100000000000
  } state_e;

  state_e  state_q, state_d;
  mul_op_e op_q, op_d;
  logic    out_pending_q, out_pending_d;

  always_comb begin
    state_d       = state_q;
    op_d          = op_q;
    out_pending_d = out_pending_q;
    cmd_o.cmd     = CMD_NONE;
    cmd_o.op      = op_q;
    in_ready_o    = 1'b0;
    case (state_q)
      S_IDLE: begin
        // A finished result may still be waiting for the output register.
        if (out_pending_q) begin
          if (status_i.out_free) begin
            cmd_o.cmd     = CMD_OUT;
            out_pending_d = 1'b0;
          end
        end else begin
          in_ready_o = 1'b1;
          if (in_valid_i) begin
            if (in_kind_i == KIND_WRITE) begin
              cmd_o.cmd = CMD_WRITE;
            end else begin
              cmd_o.cmd = CMD_START;
              state_d   = S_RDLAST;
            end
          end
        end
      end
      S_RDLAST: begin
        cmd_o.cmd = CMD_RD_LAST;
        state_d   = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.cmd = CMD_CHECK;
        if (!status_i.ok_now) begin
          state_d = S_LOAD;
        end else if (status_i.eq_mode) begin
          state_d = S_EQ;
        end else begin
          state_d = S_SRCH;
        end
      end
      S_EQ: begin
        cmd_o.cmd = CMD_EQ_INIT;
        state_d   = status_i.step_pos ? S_DIV : S_LOAD;
      end
      S_DIV: begin
        cmd_o.cmd = CMD_DIV;
        if (status_i.div_last) begin
          state_d = S_LOAD;
        end
      end
      S_SRCH: begin
        if (status_i.sr_more) begin
          cmd_o.cmd = CMD_SR_PROBE;
          state_d   = S_SCMP;
        end else begin
          cmd_o.cmd = CMD_SR_END;
          state_d   = S_LOAD;
        end
      end
      S_SCMP: begin
        cmd_o.cmd = CMD_SR_CMP;
        state_d   = S_SRCH;
      end
      S_LOAD: begin
        cmd_o.cmd = CMD_LOAD;
        state_d   = S_CAPT;
      end
      S_CAPT: begin
        cmd_o.cmd = CMD_CAPT;
        op_d      = OP_SQ;
        state_d   = S_MLO;
      end
      S_MLO: begin
        cmd_o.cmd = CMD_MUL_LO;
        state_d   = S_MHI;
      end
      S_MHI: begin
        cmd_o.cmd = CMD_MUL_HI;
        state_d   = S_MWB;
      end
      S_MWB: begin
        cmd_o.cmd = CMD_MUL_WB;
        state_d   = S_MLO;
        case (op_q)
          OP_SQ:   op_d = OP_CUBE;
          OP_CUBE: op_d = OP_LIN;
          OP_LIN:  op_d = OP_QUAD;
          OP_QUAD: op_d = OP_CUBIC;
          default: begin
            out_pending_d = 1'b1;
            state_d       = S_IDLE;
          end
        endcase
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      op_q          <= OP_SQ;
      out_pending_q <= 1'b0;
    end else begin
      state_q       <= state_d;
      op_q          <= op_d;
      out_pending_q <= out_pending_d;
    end
  end

endmodule

[hdl/cse_datapath.sv]
module cse_datapath import cse_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  in_item_t              in_data_i,
  input  ctrl_cmd_t             cmd_i,
  output dp_status_t            status_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_data_o
);

  typedef struct packed {
    logic signed [31:0] knot;
    logic signed [31:0] ca;
    logic signed [31:0] cb;
    logic signed [31:0] cc;
    logic signed [31:0] cd;
  } entry_t;

  localparam logic [2:0] DIV_TOP = 3'(IDX_W);
  localparam int DVS_W = 33 + IDX_W;
  localparam logic [MAC_W-1:0] FRAC_MASK = (MAC_W'(1) << FRAC_BITS) - MAC_W'(1);
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32'h7FFFFFFF);
  localparam logic signed [ACC_W-1:0] SAT_MIN = {{(ACC_W-31){1'b1}}, 31'b0};

  function automatic logic [32:0] mag32(input logic signed [31:0] v);
    logic [31:0] m;
    m = v[31] ? 32'(-v) : 32'(v);
    return {1'b0, m};
  endfunction

  logic [CNT_W-1:0] knot_count_q;
  logic             eq_mode_q;

  entry_t mem_q [MAX_KNOTS];
  entry_t rd_q;
  logic [IDX_W-1:0] rd_addr;

  logic signed [31:0] x_q, k0_q;
  logic               ok_q;
  logic [IDX_W-1:0]   seg_q, lo_q, hi_q, mid_q;
  logic [32:0]        step_q, rem_q;
  logic [IDX_W:0]     qt_q;
  logic [2:0]         k_q;
  logic               sdx_q;
  logic [32:0]        mdx_q;
  logic signed [31:0] cb_q, cc_q, cd_q;
  logic [48:0]        p2_q;
  logic [64:0]        p3_q;
  logic [MAC_W-1:0]   mac_q;
  logic signed [ACC_W-1:0] acc_q;
  logic               out_valid_q;
  out_item_t          out_q;

  // Effective knot count, held within its legal range.
  logic [CNT_W-1:0] n_c;
  logic [IDX_W-1:0] last_seg, last_knot;

  always_comb begin
    if (knot_count_q < CNT_W'(2)) begin
      n_c = CNT_W'(2);
    end else if (knot_count_q > CNT_W'(MAX_KNOTS)) begin
      n_c = CNT_W'(MAX_KNOTS);
    end else begin
      n_c = knot_count_q;
    end
  end

  assign last_seg  = IDX_W'(n_c - CNT_W'(2));
  assign last_knot = IDX_W'(n_c - CNT_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      knot_count_q <= RST_KNOT_COUNT;
      eq_mode_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_KNOT_COUNT:  knot_count_q <= cfg_wdata_i[CNT_W-1:0];
        CFG_EQUIDISTANT: eq_mode_q    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Binary search bounds.
  logic [IDX_W:0]   sum_c;
  logic [IDX_W-1:0] mid_c;
  logic [IDX_W:0]   span_c;

  assign sum_c  = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_c  = sum_c[IDX_W:1];
  assign span_c = {1'b0, hi_q} - {1'b0, lo_q};

  always_comb begin
    case (cmd_i.cmd)
      CMD_RD_LAST:  rd_addr = last_knot;
      CMD_CHECK:    rd_addr = IDX_W'(1);
      CMD_SR_PROBE: rd_addr = mid_c;
      CMD_LOAD:     rd_addr = seg_q;
      default:      rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmd == CMD_WRITE) begin
      mem_q[in_data_i.entry_index[IDX_W-1:0]] <= '{knot: in_data_i.knot_position,
                                                   ca:   in_data_i.coef_const,
                                                   cb:   in_data_i.coef_linear,
                                                   cc:   in_data_i.coef_quadratic,
                                                   cd:   in_data_i.coef_cubic};
    end
    rd_q <= mem_q[rd_addr];
  end

  // Range check and equidistant step, both from the word just read.
  logic               ok_now;
  logic signed [32:0] step_c, off_c, dx_c;
  logic               step_pos;

  assign ok_now   = !((x_q < k0_q) || (x_q > rd_q.knot));
  assign step_c   = {rd_q.knot[31], rd_q.knot} - {k0_q[31], k0_q};
  assign step_pos = !step_c[32] && (step_c != 33'sd0);
  assign off_c    = {x_q[31], x_q} - {k0_q[31], k0_q};
  assign dx_c     = {x_q[31], x_q} - {rd_q.knot[31], rd_q.knot};

  // Restoring division, one quotient bit a cycle; a set top bit means the
  // quotient is past every segment.
  logic [DVS_W-1:0] dvs_c;
  logic             div_ge;
  logic [IDX_W:0]   q_fin;
  logic             div_last;
  logic [IDX_W-1:0] div_seg;

  assign dvs_c    = DVS_W'(step_q) << k_q;
  assign div_ge   = DVS_W'(rem_q) >= dvs_c;
  assign q_fin    = qt_q | (div_ge ? ((IDX_W+1)'(1) << k_q) : '0);
  assign div_last = (k_q == 3'd0) || ((k_q == DIV_TOP) && div_ge);
  assign div_seg  = ((k_q == DIV_TOP) && div_ge) ? last_seg :
                    ((q_fin[IDX_W-1:0] > last_seg) ? last_seg : q_fin[IDX_W-1:0]);

  // Shared multiplier: the wide operand is taken in two halves.
  logic [64:0] mul_x;
  logic [32:0] mul_y;
  logic        mul_neg;
  logic [65:0] prod_c;
  logic [MAC_W-1:0] qm_c;
  logic signed [ACC_W-1:0] term_c;

  always_comb begin
    case (cmd_i.op)
      OP_SQ: begin
        mul_x = 65'(mdx_q); mul_y = mdx_q; mul_neg = 1'b0;
      end
      OP_CUBE: begin
        mul_x = 65'(p2_q); mul_y = mdx_q; mul_neg = sdx_q;
      end
      OP_LIN: begin
        mul_x = 65'(mdx_q); mul_y = mag32(cb_q); mul_neg = cb_q[31] ^ sdx_q;
      end
      OP_QUAD: begin
        mul_x = 65'(p2_q); mul_y = mag32(cc_q); mul_neg = cc_q[31];
      end
      default: begin
        mul_x = p3_q; mul_y = mag32(cd_q); mul_neg = cd_q[31] ^ sdx_q;
      end
    endcase
  end

  assign prod_c = (cmd_i.cmd == CMD_MUL_HI) ? (mul_x[64:32] * mul_y)
                                            : ({1'b0, mul_x[31:0]} * mul_y);
  assign qm_c   = (mac_q >> FRAC_BITS) +
                  MAC_W'(mul_neg && ((mac_q & FRAC_MASK) != '0));
  assign term_c = mul_neg ? -$signed(ACC_W'(qm_c)) : $signed(ACC_W'(qm_c));

  always_ff @(posedge clk_i) begin
    case (cmd_i.cmd)
      CMD_START: x_q <= in_data_i.query_position;
      CMD_RD_LAST: k0_q <= rd_q.knot;
      CMD_CHECK: begin
        ok_q  <= ok_now;
        seg_q <= '0;
        lo_q  <= '0;
        hi_q  <= last_knot;
      end
      CMD_EQ_INIT: begin
        if (!step_pos) begin
          seg_q <= last_seg;
        end
        step_q <= 33'(step_c);
        rem_q  <= 33'(off_c);
        qt_q   <= '0;
        k_q    <= DIV_TOP;
      end
      CMD_DIV: begin
        if (div_ge) begin
          rem_q <= rem_q - dvs_c[32:0];
        end
        qt_q <= q_fin;
        k_q  <= k_q - 3'd1;
        if (div_last) begin
          seg_q <= div_seg;
        end
      end
      CMD_SR_PROBE: mid_q <= mid_c;
      CMD_SR_CMP: begin
        if (x_q >= rd_q.knot) begin
          lo_q <= mid_q;
        end else begin
          hi_q <= mid_q;
        end
      end
      CMD_SR_END: seg_q <= (lo_q > last_seg) ? last_seg : lo_q;
      CMD_CAPT: begin
        sdx_q <= dx_c[32];
        mdx_q <= dx_c[32] ? 33'(-dx_c) : 33'(dx_c);
        cb_q  <= rd_q.cb;
        cc_q  <= rd_q.cc;
        cd_q  <= rd_q.cd;
        acc_q <= ACC_W'(rd_q.ca);
      end
      CMD_MUL_LO: mac_q <= MAC_W'(prod_c);
      CMD_MUL_HI: mac_q <= mac_q + {prod_c, 32'b0};
      CMD_MUL_WB: begin
        case (cmd_i.op)
          OP_SQ:   p2_q  <= qm_c[48:0];
          OP_CUBE: p3_q  <= qm_c[64:0];
          default: acc_q <= acc_q + term_c;
        endcase
      end
      CMD_OUT: begin
        out_q.in_range <= ok_q;
        if (acc_q > SAT_MAX) begin
          out_q.interp_value <= 32'sh7FFFFFFF;
        end else if (acc_q < SAT_MIN) begin
          out_q.interp_value <= 32'sh80000000;
        end else begin
          out_q.interp_value <= acc_q[31:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.cmd == CMD_OUT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.ok_now   = ok_now;
  assign status_o.eq_mode  = eq_mode_q;
  assign status_o.step_pos = step_pos;
  assign status_o.sr_more  = span_c > (IDX_W+1)'(1);
  assign status_o.div_last = div_last;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[test/spline_result_checker.sv]
`timescale 1ns / 100ps

module spline_result_checker import cse_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  in_item_t              in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  out_item_t             out_data_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  logic signed [31:0] knot_mem [MAX_KNOTS];
  logic signed [31:0] const_mem [MAX_KNOTS];
  logic signed [31:0] lin_mem [MAX_KNOTS];
  logic signed [31:0] quad_mem [MAX_KNOTS];
  logic signed [31:0] cubic_mem [MAX_KNOTS];
  logic [CNT_W-1:0]   knots_in_use;
  logic               equidistant;
  out_item_t          expected_values [$];
  int                 fails = 0;

  assign pending_o    = expected_values.size();
  assign fail_count_o = fails;

  function automatic out_item_t spline_value_at(logic signed [31:0] x);
    int                  n;
    int                  lo;
    int                  hi;
    int                  mid;
    int                  seg;
    logic signed [127:0] step;
    logic signed [127:0] off;
    logic signed [127:0] quot;
    logic signed [127:0] dx;
    logic signed [127:0] dx2;
    logic signed [127:0] dx3;
    logic signed [127:0] ca;
    logic signed [127:0] cb;
    logic signed [127:0] cc;
    logic signed [127:0] cd;
    logic signed [127:0] acc;
    out_item_t           r;
    n = knots_in_use;
    if (n < 2) n = 2;
    if (n > MAX_KNOTS) n = MAX_KNOTS;
    r.in_range = !(x < knot_mem[0] || x > knot_mem[n-1]);
    seg = 0;
    if (r.in_range) begin
      if (equidistant) begin
        step = knot_mem[1];
        step = step - knot_mem[0];
        off = x;
        off = off - knot_mem[0];
        if (step <= 0) begin
          seg = n - 2;
        end else begin
          quot = off / step;
          seg = (quot > n - 2) ? n - 2 : int'(quot);
        end
      end else begin
        lo = 0;
        hi = n - 1;
        while (hi - lo > 1) begin
          mid = (lo + hi) / 2;
          if (x >= knot_mem[mid]) lo = mid;
          else hi = mid;
        end
        seg = (lo > n - 2) ? n - 2 : lo;
      end
    end
    dx = x;
    dx = dx - knot_mem[seg];
    ca = const_mem[seg];
    cb = lin_mem[seg];
    cc = quad_mem[seg];
    cd = cubic_mem[seg];
    // Arithmetic right shifts give the floor that the fixed point format calls for.
    dx2 = (dx * dx) >>> FRAC_BITS;
    dx3 = (dx2 * dx) >>> FRAC_BITS;
    acc = ca + ((cb * dx) >>> FRAC_BITS) + ((cc * dx2) >>> FRAC_BITS)
        + ((cd * dx3) >>> FRAC_BITS);
    if (acc > 128'sh7fffffff) r.interp_value = 32'sh7fffffff;
    else if (acc < -128'sh80000000) r.interp_value = 32'sh80000000;
    else r.interp_value = acc[31:0];
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      knots_in_use <= RST_KNOT_COUNT;
      equidistant  <= 1'b0;
      expected_values.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_KNOT_COUNT) knots_in_use <= cfg_wdata_i;
        else if (cfg_index_i == CFG_EQUIDISTANT) equidistant <= cfg_wdata_i[0];
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_values.size() == 0) begin
          report("unexpected result", out_data_i.interp_value, '0);
        end else begin
          want = expected_values.pop_front();
          if (out_data_i.interp_value !== want.interp_value)
            report("interp_value", out_data_i.interp_value, want.interp_value);
          if (out_data_i.in_range !== want.in_range)
            report("in_range", 32'(out_data_i.in_range), 32'(want.in_range));
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.kind == KIND_WRITE) begin
          knot_mem[in_data_i.entry_index]  = in_data_i.knot_position;
          const_mem[in_data_i.entry_index] = in_data_i.coef_const;
          lin_mem[in_data_i.entry_index]   = in_data_i.coef_linear;
          quad_mem[in_data_i.entry_index]  = in_data_i.coef_quadratic;
          cubic_mem[in_data_i.entry_index] = in_data_i.coef_cubic;
        end else begin
          expected_values.push_back(spline_value_at(in_data_i.query_position));
        end
      end
    end
  end

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import cse_pkg::*;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  in_item_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  out_item_t             out_data_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  int                    fail_count;
  int                    pending;
  int                    burst_left;
  int                    cycle_count;
  logic signed [31:0]    knot_copy [MAX_KNOTS];

  cubic_spline_segment_evaluator uut (.*);

  spline_result_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // The receiver steps through three stall patterns in turn as the cycle counter advances.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      cycle_count <= 0;
    end else begin
      cycle_count <= cycle_count + 1;
      case ((cycle_count >> 8) % 3)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= $urandom_range(0, 1);
        default: out_ready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] random_coef();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return 32'sh7fffffff;
      2: return 32'sh80000000;
      default: return clip32(longint'($urandom_range(0, 1 << 19)) - (1 << 18));
    endcase
  endfunction

  task automatic send_request(input in_item_t req);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(20, 60);
      else burst_left = $urandom_range(1, 8);
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
    burst_left--;
    if (burst_left == 0) in_valid_i <= 1'b0;
  endtask

  task automatic write_entry(input int idx, input logic signed [31:0] knot);
    in_item_t req;
    req.kind           = KIND_WRITE;
    req.entry_index    = 6'(idx);
    req.knot_position  = knot;
    req.coef_const     = random_coef();
    req.coef_linear    = random_coef();
    req.coef_quadratic = random_coef();
    req.coef_cubic     = random_coef();
    req.query_position = $urandom;
    knot_copy[idx] = knot;
    send_request(req);
  endtask

  task automatic query_at(input logic signed [31:0] x);
    in_item_t req;
    req = {7'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom};
    req.kind           = KIND_QUERY;
    req.query_position = x;
    send_request(req);
  endtask

  // Lets every expected result arrive, then waits out any write still in work.
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= CFG_DATA_W'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Styles: 0 ascending, 1 random (ascending with jitter when equidistant), 2 descending, 3 spanning the whole range.
  task automatic load_table(input int count, input bit eq, input int style);
    longint sp;
    longint base;
    sp = $urandom_range(1, 1 << $urandom_range(0, 23));
    base = -(sp * (count - 1)) / 2 + $urandom_range(0, 1000) - 500;
    for (int i = 0; i < count; i++) begin
      case (style)
        1: write_entry(i, eq ? clip32(base + sp * i + $urandom_range(0, 3))
                             : clip32(longint'($urandom_range(0, 1 << 24)) - (1 << 23)));
        2: write_entry(i, clip32(-base - sp * i));
        3: write_entry(i, (i == 0) ? 32'sh80000000 :
                          (i == count - 1) ? 32'sh7fffffff : clip32(base + sp * i));
        default: write_entry(i, clip32(base + sp * i));
      endcase
    end
  endtask

  function automatic logic signed [31:0] random_position(input int n);
    int     s;
    longint lo;
    longint span;
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      2: return $urandom_range(0, 1) ? clip32(longint'(knot_copy[0]) - 1)
                                     : clip32(longint'(knot_copy[n-1]) + 1);
      3: return knot_copy[$urandom_range(0, n - 1)];
      default: begin
        s = $urandom_range(0, n - 2);
        lo = knot_copy[s];
        span = longint'(knot_copy[s+1]) - lo;
        if (span <= 0) span = $urandom_range(0, 1 << 20);
        if (span > 64'sd4000000000) span = 64'sd4000000000;
        return clip32(lo + longint'($urandom_range(0, int'(span / 2))) * 2);
      end
    endcase
  endfunction

  int knot_set [12] = '{64, 64, 2, 64, 9, 0, 127, 33, 1, 2, 20, 50};
  bit eq_set [12]   = '{0, 1, 0, 1, 1, 0, 1, 0, 1, 0, 1, 0};
  int style_set [12] = '{0, 0, 3, 0, 2, 1, 0, 1, 0, 3, 1, 0};

  initial begin
    int n;
    int idx;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = CFG_KNOT_COUNT;
    cfg_wdata_i = '0;
    burst_left  = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    for (int p = 0; p < 12; p++) begin
      n = knot_set[p];
      if (n < 2) n = 2;
      if (n > MAX_KNOTS) n = MAX_KNOTS;
      write_config(CFG_KNOT_COUNT, knot_set[p]);
      write_config(CFG_EQUIDISTANT, eq_set[p]);
      // The first pass fills the whole table so that no entry is read unwritten.
      load_table((p == 0) ? MAX_KNOTS : n, eq_set[p], style_set[p]);
      query_at(32'sh80000000);
      query_at(32'sh7fffffff);
      query_at(knot_copy[0]);
      query_at(knot_copy[n-1]);
      for (int q = 0; q < 77; q++) begin
        if ($urandom_range(0, 9) == 0) begin
          idx = $urandom_range(0, MAX_KNOTS - 1);
          write_entry(idx, knot_copy[idx]);
        end else begin
          query_at(random_position(n));
        end
      end
      drain();
    end
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
